FILE: rtl/core/sfbc_pkg.sv
// Package: shared types and codes for the segregated fit block cache.
`timescale 1ns / 1ps
package sfbc_pkg;
    localparam logic [1:0] ST_FREED  = 2'd0;
    localparam logic [1:0] ST_ALLOC  = 2'd1;
    localparam logic [1:0] ST_MISS   = 2'd2;
    localparam logic [1:0] ST_REJECT = 2'd3;
    localparam int ADDR_W = 16;
    localparam int LEN_W  = 16;
    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [LEN_W-1:0]  len_t;
endpackage

FILE: rtl/core/sfbc_ram.sv
// Generic single-port-write, one-read RAM with registered read data.
`timescale 1ns / 1ps
module sfbc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

FILE: rtl/core/segregated_fit_block_cache.sv
// Top level: segregated free-list block cache with best-fit general-list search.
`timescale 1ns / 1ps
// Freed heap blocks are kept in FIFO lists by size; allocate takes from a
// fast list or walks the general list for an exact or close fit, splitting
// a larger block and re-queuing its tail. One word is worked at a time; ready
// is low while busy. A general-list walk visits at most POOL_ENTRIES
// entries; each step issues one registered link/length memory read, waits
// for its data and compares through a single shared compare unit.
// After reset the link memory is chained as the spare pool by a clearing pass
// over all POOL_ENTRIES entries, during which no word is accepted. The result
// waits in an output register until taken; the next word may be worked
// meanwhile, and only its own result waits for the register to empty.
module segregated_fit_block_cache #(
    parameter int FAST_LISTS   = 8,
    parameter int POOL_ENTRIES = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        kind,
    input  logic [15:0] block_addr,
    input  logic [15:0] block_count,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [15:0] alloc_addr
);
    localparam int IW = $clog2(POOL_ENTRIES);
    localparam int LW = IW + 1;          // link width: extra bit is null
    localparam int CW = $clog2(FAST_LISTS);
    localparam logic [LW-1:0] LNULL = LW'(POOL_ENTRIES);

    localparam logic [3:0] S_INIT  = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_LINK  = 4'd2;  // free: wait spare link read
    localparam logic [3:0] S_FAST  = 4'd3;  // fast alloc: wait reads
    localparam logic [3:0] S_WRD   = 4'd4;  // walk: issue read
    localparam logic [3:0] S_WWT   = 4'd5;  // walk: wait data
    localparam logic [3:0] S_WCMP  = 4'd6;  // walk: compare
    localparam logic [3:0] S_BRD   = 4'd7;  // read best entry
    localparam logic [3:0] S_BWT   = 4'd8;
    localparam logic [3:0] S_UNL   = 4'd9;  // unlink best
    localparam logic [3:0] S_SPL   = 4'd10; // re-queue tail or release
    localparam logic [3:0] S_APP   = 4'd11; // append: link old tail
    localparam logic [3:0] S_OUT   = 4'd12;

    logic [3:0] state_reg, state_next;

    // class head/tail kept in flops (small, read at computed index)
    logic [LW-1:0] head_reg [FAST_LISTS];
    logic [LW-1:0] tail_reg [FAST_LISTS];
    logic [LW-1:0] spare_reg;

    sfbc_pkg::addr_t    addr_reg;
    sfbc_pkg::len_t     cnt_reg;
    logic [16:0]        limit_reg;
    logic [LW-1:0]      cur_reg, prev_reg, best_reg, bprev_reg;
    logic [16:0]        bsize_reg;
    logic [IW:0]        steps_reg;
    logic [CW-1:0]      acls_reg;    // class for pending append
    logic [LW-1:0]      aent_reg;    // entry for pending append
    logic [IW:0]        init_reg;
    logic [1:0]         st_reg;
    sfbc_pkg::addr_t    res_reg;
    logic               ov_reg;
    logic [1:0]         ost_reg;     // result word held for the receiver
    sfbc_pkg::addr_t    oaddr_reg;

    // memory ports
    logic            l_we, a_we, n_we;
    logic [IW-1:0]   l_wa, a_wa, n_wa, rd_a;
    logic [LW-1:0]   l_wd, l_rd;
    logic [15:0]     a_wd, a_rd, n_wd, n_rd;

    sfbc_ram #(.WIDTH(LW), .DEPTH(POOL_ENTRIES)) u_link (
        .clk(clk), .we(l_we), .waddr(l_wa), .wdata(l_wd), .raddr(rd_a), .rdata(l_rd));
    sfbc_ram #(.WIDTH(16), .DEPTH(POOL_ENTRIES)) u_addr (
        .clk(clk), .we(a_we), .waddr(a_wa), .wdata(a_wd), .raddr(rd_a), .rdata(a_rd));
    sfbc_ram #(.WIDTH(16), .DEPTH(POOL_ENTRIES)) u_len (
        .clk(clk), .we(n_we), .waddr(n_wa), .wdata(n_wd), .raddr(rd_a), .rdata(n_rd));

    function automatic logic [CW-1:0] cls_of(input logic [15:0] len);
        return (len < 16'(FAST_LISTS)) ? CW'(len) : '0;
    endfunction

    assign in_ready   = (state_reg == S_IDLE);
    assign out_valid  = ov_reg;
    assign status     = ost_reg;
    assign alloc_addr = oaddr_reg;

    logic        acc;
    logic        fast_req;
    logic [16:0] tail_len;
    assign acc      = in_valid && in_ready;
    assign fast_req = (block_count != 16'd0) && (block_count < 16'(FAST_LISTS));
    assign tail_len = bsize_reg - {1'b0, cnt_reg};

    // shared compare unit for the walk
    logic        c_exact, c_ge, c_take;
    assign c_exact = (n_rd == cnt_reg);
    assign c_ge    = (n_rd >= cnt_reg);
    assign c_take  = c_ge && ((best_reg != LNULL) ? ({1'b0, n_rd} < bsize_reg)
                                                  : ({1'b0, n_rd} <= limit_reg));

    always_comb
    begin
        state_next = state_reg;
        l_we = 1'b0; l_wa = '0; l_wd = '0;
        a_we = 1'b0; a_wa = '0; a_wd = '0;
        n_we = 1'b0; n_wa = '0; n_wd = '0;
        rd_a = cur_reg[IW-1:0];
        unique case (state_reg)
            S_INIT:
            begin
                l_we = 1'b1;
                l_wa = init_reg[IW-1:0];
                l_wd = LW'(init_reg) + LW'(1);
                if (init_reg == (IW+1)'(POOL_ENTRIES - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                rd_a = spare_reg[IW-1:0];
                if (acc)
                begin
                    if (!kind)
                    begin
                        state_next = (spare_reg == LNULL) ? S_OUT : S_LINK;
                        rd_a = spare_reg[IW-1:0];
                    end
                    else if (fast_req)
                    begin
                        rd_a = head_reg[CW'(block_count)][IW-1:0];
                        state_next = (head_reg[CW'(block_count)] == LNULL) ? S_OUT : S_FAST;
                    end
                    else
                    begin
                        state_next = S_WRD;
                    end
                end
            end
            S_LINK:
            begin
                a_we = 1'b1; a_wa = aent_reg[IW-1:0]; a_wd = addr_reg;
                n_we = 1'b1; n_wa = aent_reg[IW-1:0]; n_wd = cnt_reg;
                state_next = S_APP;
            end
            S_FAST:
            begin
                // release head entry to spare list
                l_we = 1'b1; l_wa = cur_reg[IW-1:0]; l_wd = spare_reg;
                state_next = S_OUT;
            end
            S_WRD:
            begin
                state_next = ((cur_reg == LNULL) || (steps_reg == (IW+1)'(POOL_ENTRIES)))
                             ? ((best_reg == LNULL) ? S_OUT : S_BRD) : S_WWT;
            end
            S_WWT:
            begin
                state_next = S_WCMP;
            end
            S_WCMP:
            begin
                state_next = c_exact ? S_BRD : S_WRD;
            end
            S_BRD:
            begin
                rd_a = best_reg[IW-1:0];
                state_next = S_BWT;
            end
            S_BWT:
            begin
                rd_a = best_reg[IW-1:0];
                state_next = S_UNL;
            end
            S_UNL:
            begin
                if (bprev_reg != LNULL)
                begin
                    l_we = 1'b1; l_wa = bprev_reg[IW-1:0]; l_wd = l_rd;
                end
                state_next = S_SPL;
            end
            S_SPL:
            begin
                if (bsize_reg > {1'b0, cnt_reg})
                begin
                    a_we = 1'b1; a_wa = best_reg[IW-1:0]; a_wd = res_reg + cnt_reg;
                    n_we = 1'b1; n_wa = best_reg[IW-1:0]; n_wd = tail_len[15:0];
                    state_next = S_APP;
                end
                else
                begin
                    l_we = 1'b1; l_wa = best_reg[IW-1:0]; l_wd = spare_reg;
                    state_next = S_OUT;
                end
            end
            S_APP:
            begin
                // null own link, then hook onto old tail (one write port: one write at a time)
                if (steps_reg[0] == 1'b0)
                begin
                    l_we = 1'b1; l_wa = aent_reg[IW-1:0]; l_wd = LNULL;
                    state_next = (tail_reg[acls_reg] == LNULL) ? S_OUT : S_APP;
                end
                else
                begin
                    l_we = 1'b1; l_wa = tail_reg[acls_reg][IW-1:0]; l_wd = aent_reg;
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!ov_reg)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            init_reg  <= '0;
            spare_reg <= '0;
            ov_reg    <= 1'b0;
            ost_reg   <= sfbc_pkg::ST_FREED;
            oaddr_reg <= '0;
            for (int i = 0; i < FAST_LISTS; i++)
            begin
                head_reg[i] <= LNULL;
                tail_reg[i] <= LNULL;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (out_valid && out_ready)
            begin
                ov_reg <= 1'b0;
            end
            unique case (state_reg)
                S_INIT:
                begin
                    init_reg <= init_reg + 1'b1;
                end
                S_IDLE:
                begin
                    if (acc)
                    begin
                        addr_reg  <= block_addr;
                        cnt_reg   <= block_count;
                        limit_reg <= 17'(({4'd0, block_count} * 20) >> 4);
                        res_reg   <= '0;
                        best_reg  <= LNULL;
                        bprev_reg <= LNULL;
                        bsize_reg <= '0;
                        prev_reg  <= LNULL;
                        steps_reg <= '0;
                        st_reg    <= sfbc_pkg::ST_MISS;
                        aent_reg  <= spare_reg;
                        acls_reg  <= cls_of(block_count);
                        if (!kind)
                        begin
                            st_reg <= (spare_reg == LNULL) ? sfbc_pkg::ST_REJECT
                                                           : sfbc_pkg::ST_FREED;
                        end
                        else if (fast_req)
                        begin
                            cur_reg <= head_reg[CW'(block_count)];
                        end
                        else
                        begin
                            cur_reg <= head_reg[0];
                        end
                    end
                end
                S_LINK:
                begin
                    spare_reg <= l_rd;
                end
                S_FAST:
                begin
                    head_reg[CW'(cnt_reg)] <= l_rd;
                    if (tail_reg[CW'(cnt_reg)] == cur_reg)
                    begin
                        tail_reg[CW'(cnt_reg)] <= LNULL;
                    end
                    res_reg   <= a_rd;
                    spare_reg <= cur_reg;
                    st_reg    <= sfbc_pkg::ST_ALLOC;
                end
                S_WCMP:
                begin
                    if (c_exact || c_take)
                    begin
                        best_reg  <= cur_reg;
                        bprev_reg <= prev_reg;
                        bsize_reg <= {1'b0, n_rd};
                    end
                    prev_reg  <= cur_reg;
                    cur_reg   <= l_rd;
                    steps_reg <= steps_reg + 1'b1;
                end
                S_UNL:
                begin
                    if (bprev_reg == LNULL)
                    begin
                        head_reg[0] <= l_rd;
                    end
                    if (tail_reg[0] == best_reg)
                    begin
                        tail_reg[0] <= bprev_reg;
                    end
                    res_reg   <= a_rd;
                    st_reg    <= sfbc_pkg::ST_ALLOC;
                    aent_reg  <= best_reg;
                    acls_reg  <= cls_of(tail_len[15:0]);
                    steps_reg <= '0;
                end
                S_SPL:
                begin
                    if (!(bsize_reg > {1'b0, cnt_reg}))
                    begin
                        spare_reg <= best_reg;
                    end
                end
                S_APP:
                begin
                    if (steps_reg[0] == 1'b0)
                    begin
                        steps_reg[0] <= 1'b1;
                        if (tail_reg[acls_reg] == LNULL)
                        begin
                            head_reg[acls_reg] <= aent_reg;
                            tail_reg[acls_reg] <= aent_reg;
                        end
                    end
                    else
                    begin
                        tail_reg[acls_reg] <= aent_reg;
                    end
                end
                S_OUT:
                begin
                    // load the result word once the output register is empty
                    if (!ov_reg)
                    begin
                        ov_reg    <= 1'b1;
                        ost_reg   <= st_reg;
                        oaddr_reg <= res_reg;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end
endmodule

FILE: sim/sfbc_checker.sv
// Checker: watches both channels, predicts the block cache results and compares.
`timescale 1ns / 1ps
module sfbc_checker #(
    parameter int FAST_LISTS   = 8,
    parameter int POOL_ENTRIES = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic        kind,
    input  logic [15:0] block_addr,
    input  logic [15:0] block_count,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [1:0]  status,
    input  logic [15:0] alloc_addr,
    output int          fail_count,
    output int          pending
);
    localparam int NIL = POOL_ENTRIES;

    typedef struct packed {
        logic [1:0]  st;
        logic [15:0] addr;
    } outcome_t;

    sfbc_pkg::addr_t blk_addr [POOL_ENTRIES];
    sfbc_pkg::len_t  blk_len  [POOL_ENTRIES];
    int              blk_next [POOL_ENTRIES];
    int              cls_head [FAST_LISTS];
    int              cls_tail [FAST_LISTS];
    int              spare;
    int              fails = 0;
    outcome_t        outcome_q [$];

    assign pending    = outcome_q.size();
    assign fail_count = fails;

    function automatic int size_class(int len);
        return (len < FAST_LISTS) ? len : 0;
    endfunction

    function automatic void enqueue(int cls, int e);
        blk_next[e] = NIL;
        if (cls_head[cls] == NIL) cls_head[cls] = e;
        else blk_next[cls_tail[cls]] = e;
        cls_tail[cls] = e;
    endfunction

    function automatic void detach(int cls, int prev, int e);
        if (prev == NIL) cls_head[cls] = blk_next[e];
        else blk_next[prev] = blk_next[e];
        if (cls_tail[cls] == e) cls_tail[cls] = prev;
    endfunction

    function automatic void recycle(int e);
        blk_next[e] = spare;
        spare = e;
    endfunction

    function automatic outcome_t serve(logic k, sfbc_pkg::addr_t a, sfbc_pkg::len_t n);
        outcome_t r;
        int e, prev, best, best_prev, best_sz, lim, sz, tail, cnt;
        cnt = int'(n);
        r.st = sfbc_pkg::ST_MISS;
        r.addr = '0;
        if (!k)
        begin
            if (spare == NIL) r.st = sfbc_pkg::ST_REJECT;
            else
            begin
                e = spare;
                spare = blk_next[e];
                blk_addr[e] = a;
                blk_len[e] = n;
                enqueue(size_class(cnt), e);
                r.st = sfbc_pkg::ST_FREED;
            end
        end
        else if (cnt > 0 && cnt < FAST_LISTS)
        begin
            e = cls_head[cnt];
            if (e != NIL)
            begin
                detach(cnt, NIL, e);
                r.addr = blk_addr[e];
                recycle(e);
                r.st = sfbc_pkg::ST_ALLOC;
            end
        end
        else
        begin
            lim = (cnt * 20) / 16;
            best = NIL;
            best_prev = NIL;
            best_sz = 0;
            prev = NIL;
            e = cls_head[0];
            while (e != NIL)
            begin
                sz = int'(blk_len[e]);
                if (sz == cnt)
                begin
                    best = e;
                    best_prev = prev;
                    best_sz = sz;
                    break;
                end
                if (sz >= cnt && ((best != NIL && sz < best_sz) || (best == NIL && sz <= lim)))
                begin
                    best = e;
                    best_prev = prev;
                    best_sz = sz;
                end
                prev = e;
                e = blk_next[e];
            end
            if (best != NIL)
            begin
                detach(0, best_prev, best);
                r.addr = blk_addr[best];
                if (best_sz > cnt)
                begin
                    tail = best_sz - cnt;
                    blk_addr[best] = sfbc_pkg::addr_t'(r.addr + n);
                    blk_len[best] = sfbc_pkg::len_t'(tail);
                    enqueue(size_class(tail), best);
                end
                else recycle(best);
                r.st = sfbc_pkg::ST_ALLOC;
            end
        end
        return r;
    endfunction

    initial
    begin
        for (int i = 0; i < POOL_ENTRIES; i++) blk_next[i] = i + 1;
        for (int i = 0; i < FAST_LISTS; i++)
        begin
            cls_head[i] = NIL;
            cls_tail[i] = NIL;
        end
        spare = 0;
    end

    always @(posedge clk)
    begin
        outcome_t want;
        if (rst_n && in_valid && in_ready)
            outcome_q.push_back(serve(kind, block_addr, block_count));
        if (rst_n && out_valid && out_ready)
        begin
            if (outcome_q.size() == 0)
            begin
                fails++;
                if (fails <= 10)
                    $display("unexpected word: status %0d addr %0h", status, alloc_addr);
            end
            else
            begin
                want = outcome_q.pop_front();
                if (want.st !== status || want.addr !== alloc_addr)
                begin
                    fails++;
                    if (fails <= 10)
                        $display("mismatch: status exp %0d got %0d, addr exp %0h got %0h",
                                 want.st, status, want.addr, alloc_addr);
                end
            end
        end
    end
endmodule

FILE: sim/tb.sv
// Testbench top: drives free and allocate words into the block cache and gives the verdict.
`timescale 1ns / 1ps
module tb;
    localparam int WATCHDOG = 20000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        kind = 1'b0;
    logic [15:0] block_addr = '0;
    logic [15:0] block_count = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [1:0]  status;
    logic [15:0] alloc_addr;
    int          fail_count;
    int          pending;
    int          idle_cycles = 0;
    bit          stall_free = 1'b0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    segregated_fit_block_cache dut (.*);

    sfbc_checker chk (.*);

    // Hold the receiver on its own pattern: mostly ready, with random stalls,
    // and a clean stretch when stall_free is set.
    always @(posedge clk)
    begin
        if (stall_free) out_ready <= 1'b1;
        else out_ready <= ($urandom_range(0, 9) < 7);
    end

    // Watchdog: count cycles with no word moving on either channel.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG)
        begin
            $display("tb NOT OK");
            $finish;
        end
    end

    // Present one word and hold it until accepted; valid then drops in the
    // next step only if no word follows at once.
    task automatic send_word(input logic k, input logic [15:0] a, input logic [15:0] n);
        kind <= k;
        block_addr <= a;
        block_count <= n;
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic go_idle();
        in_valid <= 1'b0;
    endtask

    // Pick a size: mostly the fast range and small general sizes near the
    // close-fit window, sometimes zero, near the maximum or anything at all.
    function automatic logic [15:0] pick_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 16'($urandom_range(1, 7));
        if (r < 80) return 16'($urandom_range(8, 24));
        if (r < 85) return 16'd0;
        if (r < 92) return 16'hFFFF - 16'($urandom_range(0, 3));
        return 16'($urandom);
    endfunction

    task automatic drain();
        go_idle();
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    initial
    begin
        int burst;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty misses, exact and close fits, split with wrap,
        // zero-size entries, and a full pool.
        send_word(1'b1, 16'h0, 16'd3);
        send_word(1'b1, 16'h0, 16'd100);
        send_word(1'b1, 16'h0, 16'd0);
        send_word(1'b0, 16'hFFFF, 16'hFFFF);
        send_word(1'b0, 16'h1234, 16'd0);
        send_word(1'b0, 16'h0100, 16'd20);
        send_word(1'b0, 16'h0200, 16'd18);
        send_word(1'b0, 16'h0300, 16'd3);
        send_word(1'b1, 16'hAAAA, 16'd16);
        send_word(1'b1, 16'h5555, 16'd0);
        send_word(1'b1, 16'h0, 16'd3);
        send_word(1'b1, 16'h0, 16'd3);
        send_word(1'b1, 16'h0, 16'd8);
        send_word(1'b1, 16'h0, 16'hFFFE);
        send_word(1'b1, 16'h0, 16'd2);
        send_word(1'b1, 16'h0, 16'd1);
        drain();
        for (int i = 0; i < 66; i++)
            send_word(1'b0, 16'($urandom), 16'($urandom_range(1, 7)));
        send_word(1'b1, 16'h0, 16'd7);
        send_word(1'b0, 16'hBEEF, 16'd9);
        drain();
        for (int i = 0; i < 70; i++)
            send_word(1'b1, 16'h0, 16'($urandom_range(1, 7)));
        drain();

        // Random: bursts with gaps; frees and allocates balanced so the pool
        // fills and empties. Pause once mid-run until every result is back.
        for (int i = 0; i < 900; )
        begin
            burst = $urandom_range(1, 12);
            for (int j = 0; j < burst; j++, i++)
                send_word(1'($urandom_range(0, 1)), 16'($urandom), pick_size());
            go_idle();
            if (i >= 500 && i < 500 + burst)
            begin
                stall_free = 1'b1;
                drain();
                stall_free = 1'b0;
            end
            else if ($urandom_range(0, 2) == 0)
                repeat ($urandom_range(1, 10)) @(posedge clk);
            else
                @(posedge clk);
        end
        drain();

        repeat (300) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end
endmodule
